[src/concentric_disk_hemisphere_sampler_macros.svh]
// Assertion macros for the sampler RTL.
// They assume a clock named clk and an active-low reset named arst_n in scope.
`ifndef CONCENTRIC_DISK_HEMISPHERE_SAMPLER_MACROS_SVH
`define CONCENTRIC_DISK_HEMISPHERE_SAMPLER_MACROS_SVH
`define CDHS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define CDHS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

[src/cdhs_pkg.sv]
`timescale 1ns / 1ps
package cdhs_pkg;
	localparam int ANG_FRAC = 30;
	localparam int CORDIC_STEPS = 30;
	localparam int QUOT_BITS = ANG_FRAC + 1;
	localparam int ANG_W = 32;
	localparam int TRIG_W = 33;

	typedef logic signed [ANG_W-1:0] ang_t;
	typedef logic signed [TRIG_W-1:0] trig_t;
	typedef logic [QUOT_BITS-1:0] quot_t;

	typedef struct packed {
		logic origin;
		logic swap;
		logic cneg;
		logic sneg;
	} wedge_t;

	localparam logic [ANG_FRAC-1:0] PI_QUARTER = 30'd843314857;
	localparam trig_t CORDIC_GAIN = 33'sd652032874;
	localparam trig_t TRIG_ONE = trig_t'(1) <<< ANG_FRAC;

	localparam logic [ANG_FRAC-1:0] ATAN_TAB [10] = '{
		30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
		30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149
	};

	function automatic ang_t atan_step(input int unsigned i);
		if (i < 10) begin
			return ang_t'(ATAN_TAB[i[3:0]]);
		end else begin
			return ang_t'(1) <<< (ANG_FRAC - i);
		end
	endfunction
endpackage

[src/concentric_disk_hemisphere_sampler.sv]
`timescale 1ns / 1ps
// Channel  Direction  Word fields, lowest bits first
// s_axis   in         sample_u, sample_v
// m_axis   out        disk_x, disk_y, hemi_z
//
// One word is taken per cycle while the skid register is empty.
// The pipeline depth is set by the bit-per-stage divider, the thirty CORDIC rotations and
// the digit-per-stage square root.
// Reset clears every valid bit at once; there is no clearing pass.
// A skid register behind the output register absorbs one word when the sink stalls,
// and the whole pipeline then holds until the skid register drains.
module concentric_disk_hemisphere_sampler #(
	parameter int SAMPLE_BITS = 16,
	parameter int OUT_FRAC_BITS = 15,
	localparam int IN_TW = ((2 * SAMPLE_BITS + 7) / 8) * 8,
	localparam int OUT_TW = ((3 * (OUT_FRAC_BITS + 1) + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [IN_TW-1:0]  s_axis_tdata,  // sample_u, sample_v
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [OUT_TW-1:0] m_axis_tdata   // disk_x, disk_y, hemi_z
);
	import cdhs_pkg::*;

	`include "concentric_disk_hemisphere_sampler_macros.svh"

	localparam int W = SAMPLE_BITS;
	localparam int OW = OUT_FRAC_BITS + 1;
	localparam int WW = 3 * OW;

	logic en, free;
	logic f_valid, d_valid, c_valid, l_valid;
	logic [W-1:0] f_radius, f_num, d_radius, c_radius;
	wedge_t f_wedge, d_wedge, c_wedge;
	quot_t d_quot;
	trig_t c_cos, c_sin;
	logic [OW-1:0] l_x, l_y, l_z;
	logic [WW-1:0] pipe_word;

	logic out_v_q, skid_v_q;
	logic [WW-1:0] out_q, skid_q;

	cdhs_front #(.SAMPLE_BITS(W)) u_front (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(s_axis_tvalid && s_axis_tready),
		.sample_u(s_axis_tdata[W-1:0]), .sample_v(s_axis_tdata[2*W-1:W]),
		.out_valid(f_valid), .radius(f_radius), .num(f_num), .wedge(f_wedge)
	);

	cdhs_div #(.SAMPLE_BITS(W)) u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(f_valid),
		.radius(f_radius), .num(f_num), .wedge(f_wedge),
		.out_valid(d_valid), .radius_o(d_radius), .quot(d_quot), .wedge_o(d_wedge)
	);

	cdhs_cordic #(.SAMPLE_BITS(W)) u_cordic (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(d_valid),
		.quot(d_quot), .radius(d_radius), .wedge(d_wedge),
		.out_valid(c_valid), .cos_o(c_cos), .sin_o(c_sin),
		.radius_o(c_radius), .wedge_o(c_wedge)
	);

	cdhs_lift #(.SAMPLE_BITS(W), .OUT_FRAC_BITS(OUT_FRAC_BITS)) u_lift (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(c_valid),
		.cos_i(c_cos), .sin_i(c_sin), .radius(c_radius), .wedge(c_wedge),
		.out_valid(l_valid), .disk_x(l_x), .disk_y(l_y), .hemi_z(l_z)
	);

	assign pipe_word = {l_z, l_y, l_x};
	assign en = !skid_v_q;
	assign free = !out_v_q || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = OUT_TW'(out_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (free) begin
			if (skid_v_q) begin
				out_v_q <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= l_valid;
			end
		end else if (l_valid && !skid_v_q) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (free) begin
			out_q <= skid_v_q ? skid_q : pipe_word;
		end
		if (!free && l_valid && !skid_v_q) begin
			skid_q <= pipe_word;
		end
	end

	`CDHS_ASSERT_IMP(a_skid_behind_out, skid_v_q, out_v_q, "skid word held without an output word")
	`CDHS_ASSERT_NXT(a_skid_drains, skid_v_q && m_axis_tready, !skid_v_q, "skid word not drained")
	`CDHS_ASSERT_IMP(a_ready_falls, $fell(s_axis_tready), $past(m_axis_tvalid && !m_axis_tready), "ready fell without a stalled output")
	`CDHS_ASSERT_IMP(a_origin_height, m_axis_tvalid && out_q[OW-1:0] == '0 && out_q[2*OW-1:OW] == '0, out_q[WW-1:2*OW] == (OW'(1) << OUT_FRAC_BITS), "centre point not at full height")
endmodule

[src/cdhs_front.sv]
`timescale 1ns / 1ps
module cdhs_front #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic [SAMPLE_BITS-1:0] sample_u,
	input  logic [SAMPLE_BITS-1:0] sample_v,
	output logic                   out_valid,
	output logic [SAMPLE_BITS-1:0] radius,
	output logic [SAMPLE_BITS-1:0] num,
	output cdhs_pkg::wedge_t       wedge
);
	import cdhs_pkg::*;

	localparam int W = SAMPLE_BITS;

	logic signed [W:0] sx, sy, nsx, nsy, rr, nn;
	logic [W:0] ru, au;
	logic [W-1:0] rm, an;
	logic sw, cn, neg;

	logic v_s1;
	logic [W-1:0] r_s1, num_s1;
	wedge_t wedge_s1;

	assign sx = {~sample_u[W-1], ~sample_u[W-1], sample_u[W-2:0]};
	assign sy = {~sample_v[W-1], ~sample_v[W-1], sample_v[W-2:0]};
	assign nsx = -sx;
	assign nsy = -sy;

	always_comb begin
		if (sx >= nsy) begin
			if (sx > sy) begin
				rr = sx; nn = sy; sw = 1'b0; cn = 1'b0;
			end else begin
				rr = sy; nn = sx; sw = 1'b1; cn = 1'b0;
			end
		end else begin
			if (sx <= sy) begin
				rr = nsx; nn = sy; sw = 1'b0; cn = 1'b1;
			end else begin
				rr = nsy; nn = sx; sw = 1'b1; cn = 1'b1;
			end
		end
		neg = nn[W];
		ru = rr;
		au = neg ? -nn : nn;
		rm = (ru == '0) ? W'(1) : ru[W-1:0];
		an = (au > {1'b0, rm}) ? rm : au[W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1 <= rm;
			num_s1 <= an;
			wedge_s1 <= '{origin: (sx == '0) && (sy == '0), swap: sw, cneg: cn, sneg: neg};
		end
	end

	assign out_valid = v_s1;
	assign radius = r_s1;
	assign num = num_s1;
	assign wedge = wedge_s1;
endmodule

[src/cdhs_div.sv]
`timescale 1ns / 1ps
module cdhs_div #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic [SAMPLE_BITS-1:0] radius,
	input  logic [SAMPLE_BITS-1:0] num,
	input  cdhs_pkg::wedge_t       wedge,
	output logic                   out_valid,
	output logic [SAMPLE_BITS-1:0] radius_o,
	output cdhs_pkg::quot_t        quot,
	output cdhs_pkg::wedge_t       wedge_o
);
	import cdhs_pkg::*;

	localparam int W = SAMPLE_BITS;

	logic vld_s [QUOT_BITS];
	logic [W-1:0] rem_s [QUOT_BITS];
	logic [W-1:0] den_s [QUOT_BITS];
	quot_t q_s [QUOT_BITS];
	wedge_t wdg_s [QUOT_BITS];

	for (genvar k = 0; k < QUOT_BITS; k++) begin : g_step
		logic [W:0] t;
		logic [W-1:0] r_in;
		quot_t q_in;
		wedge_t w_in;
		logic v_in, ge;

		if (k == 0) begin : g_first
			assign t = {1'b0, num};
			assign r_in = radius;
			assign q_in = '0;
			assign w_in = wedge;
			assign v_in = in_valid;
		end else begin : g_next
			assign t = {rem_s[k-1], 1'b0};
			assign r_in = den_s[k-1];
			assign q_in = q_s[k-1];
			assign w_in = wdg_s[k-1];
			assign v_in = vld_s[k-1];
		end

		assign ge = t >= {1'b0, r_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? W'(t - {1'b0, r_in}) : t[W-1:0];
				den_s[k] <= r_in;
				q_s[k] <= {q_in[QUOT_BITS-2:0], ge};
				wdg_s[k] <= w_in;
			end
		end
	end

	assign out_valid = vld_s[QUOT_BITS-1];
	assign radius_o = den_s[QUOT_BITS-1];
	assign quot = q_s[QUOT_BITS-1];
	assign wedge_o = wdg_s[QUOT_BITS-1];
endmodule

[src/cdhs_cordic.sv]
`timescale 1ns / 1ps
module cdhs_cordic #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  cdhs_pkg::quot_t        quot,
	input  logic [SAMPLE_BITS-1:0] radius,
	input  cdhs_pkg::wedge_t       wedge,
	output logic                   out_valid,
	output cdhs_pkg::trig_t        cos_o,
	output cdhs_pkg::trig_t        sin_o,
	output logic [SAMPLE_BITS-1:0] radius_o,
	output cdhs_pkg::wedge_t       wedge_o
);
	import cdhs_pkg::*;

	localparam int W = SAMPLE_BITS;
	localparam int PW = QUOT_BITS + ANG_FRAC;

	logic [PW-1:0] prod;

	logic v_s1;
	ang_t ang_s1;
	logic [W-1:0] r_s1;
	wedge_t w_s1;

	logic vld_s [CORDIC_STEPS];
	trig_t x_s [CORDIC_STEPS];
	trig_t y_s [CORDIC_STEPS];
	ang_t z_s [CORDIC_STEPS];
	logic [W-1:0] r_s [CORDIC_STEPS];
	wedge_t w_s [CORDIC_STEPS];

	assign prod = PW'(quot) * PW'(PI_QUARTER);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ang_s1 <= ang_t'(prod[PW-1:ANG_FRAC]);
			r_s1 <= radius;
			w_s1 <= wedge;
		end
	end

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
		localparam ang_t ATAN_K = atan_step(k);
		trig_t xi, yi, xs, ys;
		ang_t zi;
		logic [W-1:0] ri;
		wedge_t wi;
		logic vi;

		if (k == 0) begin : g_first
			assign xi = CORDIC_GAIN;
			assign yi = '0;
			assign zi = ang_s1;
			assign ri = r_s1;
			assign wi = w_s1;
			assign vi = v_s1;
		end else begin : g_next
			assign xi = x_s[k-1];
			assign yi = y_s[k-1];
			assign zi = z_s[k-1];
			assign ri = r_s[k-1];
			assign wi = w_s[k-1];
			assign vi = vld_s[k-1];
		end

		assign xs = xi >>> k;
		assign ys = yi >>> k;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!zi[ANG_W-1]) begin
					x_s[k] <= xi - ys;
					y_s[k] <= yi + xs;
					z_s[k] <= zi - ATAN_K;
				end else begin
					x_s[k] <= xi + ys;
					y_s[k] <= yi - xs;
					z_s[k] <= zi + ATAN_K;
				end
				r_s[k] <= ri;
				w_s[k] <= wi;
			end
		end
	end

	assign out_valid = vld_s[CORDIC_STEPS-1];
	assign cos_o = x_s[CORDIC_STEPS-1];
	assign sin_o = y_s[CORDIC_STEPS-1];
	assign radius_o = r_s[CORDIC_STEPS-1];
	assign wedge_o = w_s[CORDIC_STEPS-1];
endmodule

[src/cdhs_lift.sv]
`timescale 1ns / 1ps
module cdhs_lift #(
	parameter int SAMPLE_BITS = 16,
	parameter int OUT_FRAC_BITS = 15
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  cdhs_pkg::trig_t          cos_i,
	input  cdhs_pkg::trig_t          sin_i,
	input  logic [SAMPLE_BITS-1:0]   radius,
	input  cdhs_pkg::wedge_t         wedge,
	output logic                     out_valid,
	output logic [OUT_FRAC_BITS:0]   disk_x,
	output logic [OUT_FRAC_BITS:0]   disk_y,
	output logic [OUT_FRAC_BITS:0]   hemi_z
);
	import cdhs_pkg::*;

	localparam int W = SAMPLE_BITS;
	localparam int OW = OUT_FRAC_BITS + 1;
	localparam int MW = ANG_FRAC + 1;
	localparam int PW = W + MW;
	localparam int SH = W - 1 + ANG_FRAC - OUT_FRAC_BITS;
	localparam int VW = PW + 1 - SH;
	localparam int SQW = 2 * OW;
	localparam int DW = 2 * OUT_FRAC_BITS + 1;
	localparam int RS = OUT_FRAC_BITS + 1;
	localparam logic [PW:0] HALF = (PW + 1)'(1) << (SH - 1);
	localparam logic [VW-1:0] LIM_NEG = VW'(1) << OUT_FRAC_BITS;
	localparam logic [VW-1:0] LIM_POS = LIM_NEG - VW'(1);
	localparam logic [SQW:0] ONE_SQ = (SQW + 1)'(1) << (2 * OUT_FRAC_BITS);

	function automatic logic [MW-1:0] clamp_trig(input trig_t t);
		if (t[TRIG_W-1]) begin
			return '0;
		end else if (t > TRIG_ONE) begin
			return TRIG_ONE[MW-1:0];
		end else begin
			return t[MW-1:0];
		end
	endfunction

	function automatic logic [OW-1:0] round_sat(input logic [PW-1:0] p, input logic neg);
		logic [PW:0] t;
		logic [VW-1:0] v, m;
		t = {1'b0, p} + HALF;
		v = t[PW:SH];
		if (neg) begin
			m = (v > LIM_NEG) ? LIM_NEG : v;
		end else begin
			m = (v > LIM_POS) ? LIM_POS : v;
		end
		return neg ? OW'(-m) : m[OW-1:0];
	endfunction

	logic [MW-1:0] cm, sm;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [MW-1:0] mx_s1, my_s1;
	logic [W-1:0] r_s1;
	logic xn_s1, yn_s1, org_s1;
	logic [PW-1:0] px_s2, py_s2;
	logic xn_s2, yn_s2, org_s2;
	logic [OW-1:0] x_s3, y_s3, x_s4, y_s4, x_s5, y_s5;
	logic [SQW-1:0] sqx_s4, sqy_s4;
	logic [SQW:0] sum;
	logic [OW-1:0] ax, ay;
	logic [DW-1:0] d_s5;
	logic zero_s5;
	logic [OW-1:0] x_s6, y_s6, z_s6;

	logic rv_s [RS];
	logic [DW-1:0] rd_s [RS];
	logic [DW-1:0] rt_s [RS];
	logic rz_s [RS];
	logic [OW-1:0] rx_s [RS];
	logic [OW-1:0] ry_s [RS];

	assign cm = clamp_trig(cos_i);
	assign sm = clamp_trig(sin_i);
	assign ax = x_s3[OW-1] ? OW'(-x_s3) : x_s3;
	assign ay = y_s3[OW-1] ? OW'(-y_s3) : y_s3;
	assign sum = {1'b0, sqx_s4} + {1'b0, sqy_s4};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= rv_s[RS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s1 <= wedge.swap ? sm : cm;
			my_s1 <= wedge.swap ? cm : sm;
			xn_s1 <= wedge.swap ? wedge.sneg : wedge.cneg;
			yn_s1 <= wedge.swap ? wedge.cneg : wedge.sneg;
			org_s1 <= wedge.origin;
			r_s1 <= radius;

			px_s2 <= PW'(r_s1) * PW'(mx_s1);
			py_s2 <= PW'(r_s1) * PW'(my_s1);
			xn_s2 <= xn_s1;
			yn_s2 <= yn_s1;
			org_s2 <= org_s1;

			x_s3 <= org_s2 ? '0 : round_sat(px_s2, xn_s2);
			y_s3 <= org_s2 ? '0 : round_sat(py_s2, yn_s2);

			sqx_s4 <= SQW'(ax) * SQW'(ax);
			sqy_s4 <= SQW'(ay) * SQW'(ay);
			x_s4 <= x_s3;
			y_s4 <= y_s3;

			zero_s5 <= sum >= ONE_SQ;
			d_s5 <= DW'(ONE_SQ - sum);
			x_s5 <= x_s4;
			y_s5 <= y_s4;

			z_s6 <= rz_s[RS-1] ? '0 :
				((rd_s[RS-1] > rt_s[RS-1]) ? OW'(rt_s[RS-1] + DW'(1)) : OW'(rt_s[RS-1]));
			x_s6 <= rx_s[RS-1];
			y_s6 <= ry_s[RS-1];
		end
	end

	for (genvar k = 0; k < RS; k++) begin : g_root
		localparam logic [DW-1:0] BIT_K = DW'(1) << (2 * (OUT_FRAC_BITS - k));
		logic [DW-1:0] di, ti;
		logic [DW:0] trial;
		logic vi, zi, ge;
		logic [OW-1:0] xi, yi;

		if (k == 0) begin : g_first
			assign di = d_s5;
			assign ti = '0;
			assign vi = v_s5;
			assign zi = zero_s5;
			assign xi = x_s5;
			assign yi = y_s5;
		end else begin : g_next
			assign di = rd_s[k-1];
			assign ti = rt_s[k-1];
			assign vi = rv_s[k-1];
			assign zi = rz_s[k-1];
			assign xi = rx_s[k-1];
			assign yi = ry_s[k-1];
		end

		assign trial = {1'b0, ti} + {1'b0, BIT_K};
		assign ge = {1'b0, di} >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rv_s[k] <= 1'b0;
			end else if (en) begin
				rv_s[k] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rd_s[k] <= ge ? DW'({1'b0, di} - trial) : di;
				rt_s[k] <= ge ? ((ti >> 1) + BIT_K) : (ti >> 1);
				rz_s[k] <= zi;
				rx_s[k] <= xi;
				ry_s[k] <= yi;
			end
		end
	end

	assign out_valid = v_s6;
	assign disk_x = x_s6;
	assign disk_y = y_s6;
	assign hemi_z = z_s6;
endmodule
